// ===== hdl/mt_pkg.sv =====
// ----------------------------------------------------------------------------
// MT19937 shared definitions
// Word widths, recurrence constants, request codes and the twist and temper
// functions that the generator uses.
// ----------------------------------------------------------------------------
package mt_pkg;

  localparam int WORD_W      = 32;
  localparam int STATE_WORDS = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W       = $clog2(STATE_WORDS);

  localparam logic [WORD_W-1:0] SEED_MULT    = 32'h6c078965;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

  localparam int SEED_SHIFT = 30;
  localparam int TEMPER_U   = 11;
  localparam int TEMPER_S   = 7;
  localparam int TEMPER_T   = 15;
  localparam int TEMPER_L   = 18;

  // Request codes on req_type
  typedef enum logic {
    REQ_SEED = 1'b0,
    REQ_NEXT = 1'b1
  } req_t;

  // Seeding unit to top level: shift request and word for the chain tail
  typedef struct packed {
    logic              load;
    logic              busy;
    logic [WORD_W-1:0] word;
  } seed_ctl_t;

  // One step of the twist recurrence
  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] head,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = (head & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  // Output tempering
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> TEMPER_U);
    y = y ^ ((y << TEMPER_S) & TEMPER_B);
    y = y ^ ((y << TEMPER_T) & TEMPER_C);
    y = y ^ (y >> TEMPER_L);
    return y;
  endfunction

endpackage

// ===== hdl/mt_cell.sv =====
// ----------------------------------------------------------------------------
// MT state cell
// One word of generator state; loads its neighbour's word on each shift.
// ----------------------------------------------------------------------------
module mt_cell
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [WORD_W-1:0] d,
  output logic [WORD_W-1:0] q
);

  // Payload only, no reset needed
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== hdl/mt_chain.sv =====
// ----------------------------------------------------------------------------
// MT state chain
// Row of state cells forming a circular shift line. Cell 0 holds the oldest
// word; new words enter at the tail. Fixed taps feed the twist.
// ----------------------------------------------------------------------------
module mt_chain
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [WORD_W-1:0] tail_in,
  output logic [WORD_W-1:0] head,
  output logic [WORD_W-1:0] nxt,
  output logic [WORD_W-1:0] far,
  output logic [WORD_W-1:0] tail
);

  logic [WORD_W-1:0] cell_q [STATE_WORDS];

  // Each cell takes its upper neighbour; the last takes the new word
  for (genvar j = 0; j < STATE_WORDS; j++) begin : g_cell
    logic [WORD_W-1:0] cell_d;
    if (j == STATE_WORDS - 1) begin : g_tail
      assign cell_d = tail_in;
    end else begin : g_body
      assign cell_d = cell_q[j+1];
    end
    mt_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (cell_d),
      .q     (cell_q[j])
    );
  end

  assign head = cell_q[0];
  assign nxt  = cell_q[1];
  assign far  = cell_q[TWIST_OFFSET];
  assign tail = cell_q[STATE_WORDS-1];

endmodule

// ===== hdl/mt_seeder.sv =====
// ----------------------------------------------------------------------------
// MT seeding unit
// Runs the multiplicative seed recurrence, one word per cycle, feeding the
// chain tail from the word that entered it the cycle before.
// ----------------------------------------------------------------------------
module mt_seeder
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] seed_value,
  input  logic [WORD_W-1:0] prev,
  output seed_ctl_t         ctl
);

  logic             busy;
  logic [IDX_W-1:0] count;
  logic [WORD_W-1:0] mixed;

  // Word counter: the seed itself goes in on the start cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= IDX_W'(1);
    end else if (busy) begin
      count <= count + IDX_W'(1);
      if (count == IDX_W'(STATE_WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // t[i] = mult * (p ^ (p >> 30)) + i, modulo 2^32
  always_comb begin
    mixed    = prev ^ (prev >> SEED_SHIFT);
    ctl.load = start | busy;
    ctl.busy = busy;
    if (start) begin
      ctl.word = seed_value;
    end else begin
      ctl.word = (mixed * SEED_MULT) + WORD_W'(count);
    end
  end

endmodule

// ===== hdl/mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// MT19937 random word generator
// Seedable 32-bit generator built on a circular chain of state cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): req_type selects seed or next;
//   seed_value is used by seed requests only.
//   Output channel (out_valid / out_stall): random_value, one beat per next
//   request; seed requests give no beat.
//   A next request is answered in the cycle after acceptance. The twist runs
//   one word per next request as the chain rotates, so next requests are
//   taken every cycle while the output register is free or being emptied.
//   A seed request shifts the recurrence through all 624 cells, one word
//   a cycle through the seeding multiplier: in_stall is held high after the
//   seed beat until the last word has entered the chain.
//   Reset empties the output register and marks the block unseeded; next
//   requests before the first seed return zero.
//   While out_stall is high with a beat waiting, the beat holds and
//   in_stall is raised.
// ----------------------------------------------------------------------------
module mersenne_twister_generator
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [WORD_W-1:0] seed_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] random_value
);

  logic              accept;
  logic              seed_start;
  logic              next_go;
  logic              seeded;
  logic              shift;
  logic [WORD_W-1:0] head;
  logic [WORD_W-1:0] nxt;
  logic [WORD_W-1:0] far;
  logic [WORD_W-1:0] tail;
  logic [WORD_W-1:0] tail_in;
  logic [WORD_W-1:0] twisted;
  seed_ctl_t         seed_ctl;

  // Input handshake
  assign in_stall   = seed_ctl.busy | (out_valid & out_stall);
  assign accept     = in_valid & ~in_stall;
  assign seed_start = accept & (req_t'(req_type) == REQ_SEED);
  assign next_go    = accept & (req_t'(req_type) == REQ_NEXT);

  mt_seeder u_seeder (
    .clk        (clk),
    .rst        (rst),
    .start      (seed_start),
    .seed_value (seed_value),
    .prev       (tail),
    .ctl        (seed_ctl)
  );

  // Chain feed: seed recurrence while seeding, else the twisted word
  always_comb begin
    twisted = twist_word(head, nxt, far);
    shift   = seed_ctl.load | next_go;
    tail_in = seed_ctl.load ? seed_ctl.word : twisted;
  end

  mt_chain u_chain (
    .clk     (clk),
    .shift   (shift),
    .tail_in (tail_in),
    .head    (head),
    .nxt     (nxt),
    .far     (far),
    .tail    (tail)
  );

  // Seeded flag: chain cells have no reset, so unseeded outputs are forced to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= 1'b0;
    end else if (seed_start) begin
      seeded <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (next_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (next_go) begin
      random_value <= seeded ? temper(twisted) : '0;
    end
  end

endmodule

// ===== hdl/mt_checker.sv =====
// ----------------------------------------------------------------------------
// MT generator port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module mt_checker
  import mt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              req_type,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] random_value
);

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(random_value))
    else $error("output beat changed while stalled");

  // A next request is answered on the following cycle
  a_next_answered: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_t'(req_type) == REQ_NEXT) |=> out_valid)
    else $error("next request gave no beat");

  // A seed request gives no beat
  a_seed_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_t'(req_type) == REQ_SEED) && !out_valid
    |=> !out_valid)
    else $error("seed request gave a beat");

  // Seeding holds off the input channel
  a_seed_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_t'(req_type) == REQ_SEED) |=> in_stall)
    else $error("input taken during seeding");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("beat present after reset");

endmodule

bind mersenne_twister_generator mt_checker u_mt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .req_type     (req_type),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .random_value (random_value)
);
